@@ rtl/sspmv_pkg.sv @@
package sspmv_pkg;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_ENTRY = 2'd1,
    FUNC_EVAL  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_E_RD,
    ST_E_MUL,
    ST_E_ACC,
    ST_V_RD,
    ST_V_SUB,
    ST_V_MUL,
    ST_V_CMP,
    ST_V_OUT
  } state_e;

  localparam logic [1:0] CFG_MATRIX_ORDER = 2'd0;
  localparam logic [1:0] CFG_RHS_COUNT    = 2'd1;

  localparam int unsigned MAX_ORDER = 1024;
  localparam int unsigned MAX_RHS   = 4;

  localparam int unsigned ORDER_W = 11;
  localparam int unsigned RHS_W   = 3;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned SQ_W    = 63;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [SQ_W-1:0]         SQ_MAX  = {SQ_W{1'b1}};
  localparam logic [48:0]             ROOT_LIMIT = 49'd3037000499;

endpackage

@@ rtl/symmetric_spmv_residual_check.sv @@
// channel   direction  handshake                    payload
// command   in         start_i & !busy_o            func, row/col index, entry, rhs, x, b
// result    out        result_valid_o (1 cycle)     rhs_number, max_sq_error, last_result
// config    in         cfg_valid_i & cfg_ready_o    cfg_index_i, cfg_data_i
//
// a load finishes in the accept cycle; an entry runs ST_E_RD, ST_E_MUL and ST_E_ACC
// per update on the shared multiplier (1 or 2 updates per right-hand side)
// an evaluate runs ST_V_RD, ST_V_SUB, ST_V_MUL and ST_V_CMP per row, plus ST_V_OUT
// per right-hand side, then a clearing pass over all MAX_ORDER*MAX_RHS accumulator words
// the same clearing pass runs after reset; busy_o is high and cfg_ready_o low throughout
// results are shown for one cycle only; the receiver cannot stall them
module symmetric_spmv_residual_check (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          func_i,
  input  logic [9:0]          row_index_i,
  input  logic [9:0]          col_index_i,
  input  logic signed [31:0]  entry_value_i,
  input  logic [1:0]          rhs_select_i,
  input  logic signed [31:0]  x_value_i,
  input  logic signed [31:0]  b_value_i,
  output logic                result_valid_o,
  output logic [1:0]          rhs_number_o,
  output logic [62:0]         max_sq_error_o,
  output logic                last_result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [10:0]         cfg_data_i
);

  localparam int unsigned DEPTH = sspmv_pkg::MAX_ORDER * sspmv_pkg::MAX_RHS;
  localparam int unsigned AW    = $clog2(DEPTH);

  sspmv_pkg::state_e state_q, state_d;

  logic [sspmv_pkg::ORDER_W-1:0] order_q;
  logic [sspmv_pkg::RHS_W-1:0]   rhs_q;
  logic [sspmv_pkg::ORDER_W-1:0] n_eff;
  logic [sspmv_pkg::RHS_W-1:0]   m_eff;

  logic [9:0]         row_q, row_d, col_q, col_d;
  logic signed [31:0] v_q, v_d;
  logic [sspmv_pkg::RHS_W-1:0]   r_q, r_d;
  logic [sspmv_pkg::ORDER_W-1:0] i_q, i_d;
  logic               phase_q, phase_d;
  logic [62:0]        best_q, best_d;
  logic [31:0]        a_q, a_d;
  logic               sat_q, sat_d;
  logic signed [63:0] prod_q, prod_d;
  logic [AW-1:0]      clr_q, clr_d;

  // memories
  logic [63:0]              xb_mem [DEPTH];
  logic signed [sspmv_pkg::ACC_W-1:0] y_mem [DEPTH];
  logic [63:0]              xb_rdata_q;
  logic signed [sspmv_pkg::ACC_W-1:0] y_rdata_q;
  logic [AW-1:0]            xb_raddr, y_raddr, y_waddr, ld_addr;
  logic                     y_we, ld_we;
  logic signed [sspmv_pkg::ACC_W-1:0] y_wdata;

  logic                     accept;
  logic signed [32:0]       mul_a, mul_b;
  logic signed [63:0]       rnd;
  logic signed [48:0]       acc_sum;
  logic signed [48:0]       diff;
  logic [48:0]              absd;
  logic [62:0]              sq;

  always_comb begin
    if (order_q == '0) n_eff = sspmv_pkg::ORDER_W'(1);
    else if (32'(order_q) > sspmv_pkg::MAX_ORDER) n_eff = sspmv_pkg::ORDER_W'(sspmv_pkg::MAX_ORDER);
    else n_eff = order_q;
    if (rhs_q == '0) m_eff = sspmv_pkg::RHS_W'(1);
    else if (32'(rhs_q) > sspmv_pkg::MAX_RHS) m_eff = sspmv_pkg::RHS_W'(sspmv_pkg::MAX_RHS);
    else m_eff = rhs_q;
  end

  assign busy_o      = (state_q != sspmv_pkg::ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= sspmv_pkg::ORDER_W'(1);
      rhs_q   <= sspmv_pkg::RHS_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        sspmv_pkg::CFG_MATRIX_ORDER: order_q <= cfg_data_i;
        sspmv_pkg::CFG_RHS_COUNT:    rhs_q   <= cfg_data_i[sspmv_pkg::RHS_W-1:0];
        default: ;
      endcase
    end
  end

  // load path writes x and b straight from the command word
  assign ld_addr = AW'(32'(rhs_select_i) * sspmv_pkg::MAX_ORDER + 32'(row_index_i));
  assign ld_we   = accept && (func_i == sspmv_pkg::FUNC_LOAD) &&
                   (11'(row_index_i) < n_eff) && (3'(rhs_select_i) < m_eff);

  always_comb begin
    if (state_q == sspmv_pkg::ST_V_RD || state_q == sspmv_pkg::ST_V_SUB) begin
      xb_raddr = AW'(32'(r_q) * sspmv_pkg::MAX_ORDER + 32'(i_q));
      y_raddr  = xb_raddr;
    end else begin
      xb_raddr = AW'(32'(r_q) * sspmv_pkg::MAX_ORDER + 32'(phase_q ? row_q : col_q));
      y_raddr  = AW'(32'(r_q) * sspmv_pkg::MAX_ORDER + 32'(phase_q ? col_q : row_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_we) xb_mem[ld_addr] <= {x_value_i, b_value_i};
    xb_rdata_q <= xb_mem[xb_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (y_we) y_mem[y_waddr] <= y_wdata;
    y_rdata_q <= y_mem[y_raddr];
  end

  // shared multiplier: signed products for entries, unsigned squares for residuals
  always_comb begin
    if (state_q == sspmv_pkg::ST_V_MUL) begin
      mul_a = {1'b0, a_q};
      mul_b = {1'b0, a_q};
    end else begin
      mul_a = {v_q[31], v_q};
      mul_b = {xb_rdata_q[63], xb_rdata_q[63:32]};
    end
  end

  // round to q32.16, then saturating add
  assign rnd     = (prod_q + 64'sd32768) >>> 16;
  assign acc_sum = {y_rdata_q[sspmv_pkg::ACC_W-1], y_rdata_q} +
                   {rnd[sspmv_pkg::ACC_W-1], rnd[sspmv_pkg::ACC_W-1:0]};

  assign diff = {y_rdata_q[sspmv_pkg::ACC_W-1], y_rdata_q} -
                49'(signed'(xb_rdata_q[31:0]));
  assign absd = diff[48] ? 49'(-diff) : 49'(diff);
  assign sq   = sat_q ? sspmv_pkg::SQ_MAX : prod_q[62:0];

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    v_d     = v_q;
    r_d     = r_q;
    i_d     = i_q;
    phase_d = phase_q;
    best_d  = best_q;
    a_d     = a_q;
    sat_d   = sat_q;
    prod_d  = prod_q;
    clr_d   = clr_q;
    y_we    = 1'b0;
    y_waddr = y_raddr;
    y_wdata = '0;
    result_valid_o = 1'b0;

    case (state_q)
      sspmv_pkg::ST_IDLE: begin
        if (accept) begin
          row_d   = row_index_i;
          col_d   = col_index_i;
          v_d     = entry_value_i;
          r_d     = '0;
          i_d     = '0;
          phase_d = 1'b0;
          best_d  = '0;
          case (func_i)
            sspmv_pkg::FUNC_ENTRY: begin
              if (11'(row_index_i) < n_eff && 11'(col_index_i) < n_eff)
                state_d = sspmv_pkg::ST_E_RD;
            end
            sspmv_pkg::FUNC_EVAL: state_d = sspmv_pkg::ST_V_RD;
            default: ;
          endcase
        end
      end
      sspmv_pkg::ST_CLEAR: begin
        y_we    = 1'b1;
        y_waddr = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == AW'(DEPTH - 1)) state_d = sspmv_pkg::ST_IDLE;
      end
      sspmv_pkg::ST_E_RD: state_d = sspmv_pkg::ST_E_MUL;
      sspmv_pkg::ST_E_MUL: begin
        prod_d  = 64'(mul_a * mul_b);
        state_d = sspmv_pkg::ST_E_ACC;
      end
      sspmv_pkg::ST_E_ACC: begin
        y_we = 1'b1;
        if (acc_sum[48] != acc_sum[47])
          y_wdata = acc_sum[48] ? sspmv_pkg::ACC_MIN : sspmv_pkg::ACC_MAX;
        else
          y_wdata = acc_sum[sspmv_pkg::ACC_W-1:0];
        state_d = sspmv_pkg::ST_E_RD;
        if (!phase_q && row_q != col_q) begin
          phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
          if (r_q == m_eff - 1'b1) state_d = sspmv_pkg::ST_IDLE;
          else r_d = r_q + 1'b1;
        end
      end
      sspmv_pkg::ST_V_RD: state_d = sspmv_pkg::ST_V_SUB;
      sspmv_pkg::ST_V_SUB: begin
        sat_d   = absd > sspmv_pkg::ROOT_LIMIT;
        a_d     = absd[31:0];
        state_d = sspmv_pkg::ST_V_MUL;
      end
      sspmv_pkg::ST_V_MUL: begin
        prod_d  = 64'(mul_a * mul_b);
        state_d = sspmv_pkg::ST_V_CMP;
      end
      sspmv_pkg::ST_V_CMP: begin
        if (sq > best_q) best_d = sq;
        if (i_q == n_eff - 1'b1) begin
          state_d = sspmv_pkg::ST_V_OUT;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = sspmv_pkg::ST_V_RD;
        end
      end
      sspmv_pkg::ST_V_OUT: begin
        result_valid_o = 1'b1;
        i_d    = '0;
        best_d = '0;
        if (r_q == m_eff - 1'b1) begin
          clr_d   = '0;
          state_d = sspmv_pkg::ST_CLEAR;
        end else begin
          r_d     = r_q + 1'b1;
          state_d = sspmv_pkg::ST_V_RD;
        end
      end
      default: state_d = sspmv_pkg::ST_IDLE;
    endcase
  end

  assign rhs_number_o   = r_q[1:0];
  assign max_sq_error_o = best_q;
  assign last_result_o  = (r_q == m_eff - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sspmv_pkg::ST_CLEAR;
      clr_q   <= '0;
      r_q     <= '0;
      i_q     <= '0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      r_q     <= r_d;
      i_q     <= i_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    col_q  <= col_d;
    v_q    <= v_d;
    best_q <= best_d;
    a_q    <= a_d;
    sat_q  <= sat_d;
    prod_q <= prod_d;
  end

endmodule

@@ dv/tb_symmetric_spmv_residual_check.sv @@
module tb_symmetric_spmv_residual_check;

  localparam int unsigned ORDER_MAX = 1024;
  localparam int unsigned RHS_MAX   = 4;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam logic [62:0] SQ_SAT = {63{1'b1}};
  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;

  typedef struct packed {
    logic [1:0]  rhs;
    logic [62:0] err;
    logic        last;
  } residual_t;

  class residual_scoreboard;
    logic signed [31:0] x_mem[ORDER_MAX*RHS_MAX];
    logic signed [31:0] b_mem[ORDER_MAX*RHS_MAX];
    longint             y_mem[ORDER_MAX*RHS_MAX];
    int unsigned        order_eff;
    int unsigned        rhs_eff;
    residual_t          residual_q[$];
    int                 errors;
    int                 n_checked;

    function new();
      foreach (y_mem[i]) begin
        y_mem[i] = 0;
        x_mem[i] = '0;
        b_mem[i] = '0;
      end
      order_eff = 1;
      rhs_eff   = 1;
      errors    = 0;
      n_checked = 0;
    endfunction

    task report(string msg);
      $display("ERROR %s", msg);
      errors++;
    endtask

    function void set_reg(logic [1:0] idx, logic [10:0] data);
      if (idx == sspmv_pkg::CFG_MATRIX_ORDER)
        order_eff = (data == 0) ? 1 : (data > ORDER_MAX) ? ORDER_MAX : data;
      else if (idx == sspmv_pkg::CFG_RHS_COUNT)
        rhs_eff = (data[2:0] == 0) ? 1 : (data[2:0] > RHS_MAX) ? RHS_MAX : data[2:0];
    endfunction

    // Q16.16 * Q16.16 rounded half up to Q32.16
    function longint rounded_product(longint v, longint x);
      longint q;
      q = v * x + 32768;
      return q >>> 16;
    endfunction

    function void accumulate(int unsigned idx, longint t);
      longint s;
      s = y_mem[idx] + t;
      if (s > ACC_HI) s = ACC_HI;
      if (s < ACC_LO) s = ACC_LO;
      y_mem[idx] = s;
    endfunction

    function void note_command(sspmv_pkg::func_e f, logic [9:0] row, logic [9:0] col,
                               logic signed [31:0] v, logic [1:0] sel,
                               logic signed [31:0] x, logic signed [31:0] b);
      int unsigned base;
      longint d;
      longint unsigned a, sq, best;
      residual_t res;
      case (f)
        sspmv_pkg::FUNC_LOAD: begin
          if (row < order_eff && sel < rhs_eff) begin
            x_mem[sel*ORDER_MAX + row] = x;
            b_mem[sel*ORDER_MAX + row] = b;
          end
        end
        sspmv_pkg::FUNC_ENTRY: begin
          if (row < order_eff && col < order_eff) begin
            for (int r = 0; r < rhs_eff; r++) begin
              base = r * ORDER_MAX;
              accumulate(base + row, rounded_product(v, x_mem[base + col]));
              if (row != col)
                accumulate(base + col, rounded_product(v, x_mem[base + row]));
            end
          end
        end
        sspmv_pkg::FUNC_EVAL: begin
          for (int r = 0; r < rhs_eff; r++) begin
            base = r * ORDER_MAX;
            best = 0;
            for (int i = 0; i < order_eff; i++) begin
              d = y_mem[base + i] - longint'(b_mem[base + i]);
              a = (d < 0) ? -d : d;
              sq = (a > 64'd3037000499) ? 64'h7FFF_FFFF_FFFF_FFFF : a * a;
              if (sq > best) best = sq;
            end
            res.rhs  = r[1:0];
            res.err  = best[62:0];
            res.last = (r + 1 == rhs_eff);
            residual_q.push_back(res);
          end
          foreach (y_mem[i]) y_mem[i] = 0;
        end
        default: ;
      endcase
    endfunction

    task check_result(logic [1:0] rhs, logic [62:0] err, logic last);
      residual_t exp_r;
      n_checked++;
      if (residual_q.size() == 0) begin
        report($sformatf("unexpected result rhs=%0d err=%0h", rhs, err));
      end else begin
        exp_r = residual_q.pop_front();
        if (rhs !== exp_r.rhs)
          report($sformatf("rhs_number got %0d want %0d", rhs, exp_r.rhs));
        if (err !== exp_r.err)
          report($sformatf("max_sq_error rhs %0d got %0h want %0h", exp_r.rhs, err, exp_r.err));
        if (last !== exp_r.last)
          report($sformatf("last_result rhs %0d got %0b want %0b", exp_r.rhs, last, exp_r.last));
      end
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         func_i = '0;
  logic [9:0]         row_index_i = '0;
  logic [9:0]         col_index_i = '0;
  logic signed [31:0] entry_value_i = '0;
  logic [1:0]         rhs_select_i = '0;
  logic signed [31:0] x_value_i = '0;
  logic signed [31:0] b_value_i = '0;
  logic               result_valid_o;
  logic [1:0]         rhs_number_o;
  logic [62:0]        max_sq_error_o;
  logic               last_result_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [10:0]        cfg_data_i = '0;

  residual_scoreboard sb = new();
  bit                 loaded[ORDER_MAX*RHS_MAX];
  bit                 no_gaps;
  int                 cycles;
  int                 words_sent;
  int                 evals_sent;

  symmetric_spmv_residual_check uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("symmetric_spmv_residual_check: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && result_valid_o)
      sb.check_result(rhs_number_o, max_sq_error_o, last_result_o);

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(8) << 16;
      3: return -($urandom_range(8) << 16);
      default: return $urandom;
    endcase
  endfunction

  task automatic send(sspmv_pkg::func_e f, logic [9:0] row, logic [9:0] col, logic [31:0] v,
                      logic [1:0] sel, logic [31:0] x, logic [31:0] b);
    func_i        <= f;
    row_index_i   <= row;
    col_index_i   <= col;
    entry_value_i <= v;
    rhs_select_i  <= sel;
    x_value_i     <= x;
    b_value_i     <= b;
    start_i       <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    sb.note_command(f, row, col, v, sel, x, b);
    if (f == sspmv_pkg::FUNC_LOAD && row < sb.order_eff && sel < sb.rhs_eff)
      loaded[sel*ORDER_MAX + row] = 1'b1;
    words_sent++;
    if (f == sspmv_pkg::FUNC_EVAL) evals_sent++;
    if (!no_gaps && $urandom_range(99) < 33) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic load(logic [9:0] row, logic [1:0] sel, logic [31:0] x, logic [31:0] b);
    send(sspmv_pkg::FUNC_LOAD, row, 10'($urandom), $urandom, sel, x, b);
  endtask

  task automatic entry(logic [9:0] row, logic [9:0] col, logic [31:0] v);
    send(sspmv_pkg::FUNC_ENTRY, row, col, v, 2'($urandom), $urandom, $urandom);
  endtask

  task automatic evaluate();
    send(sspmv_pkg::FUNC_EVAL, 10'($urandom), 10'($urandom), $urandom, 2'($urandom),
         $urandom, $urandom);
  endtask

  // block must be idle: no pending results and the clearing pass done
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.residual_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] data);
    drain();
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  // every active position gets x and b before any entry or evaluate reads it
  task automatic fill_vectors();
    for (int s = 0; s < sb.rhs_eff; s++)
      for (int r = 0; r < sb.order_eff; r++)
        if (!loaded[s*ORDER_MAX + r]) load(10'(r), 2'(s), pick_value(), pick_value());
  endtask

  task automatic random_phase(logic [10:0] order_w, logic [10:0] rhs_w, int n_words);
    int unsigned n, m, p, rr, cc;
    write_reg(sspmv_pkg::CFG_MATRIX_ORDER, order_w);
    write_reg(sspmv_pkg::CFG_RHS_COUNT, rhs_w);
    n = sb.order_eff;
    m = sb.rhs_eff;
    fill_vectors();
    for (int k = 0; k < n_words; k++) begin
      p  = $urandom_range(99);
      rr = $urandom_range(n - 1);
      cc = $urandom_range(n - 1);
      if (p < 55)
        entry(10'(rr), 10'(cc), pick_value());
      else if (p < 68)
        load(10'(rr), 2'($urandom_range(m - 1)), pick_value(), pick_value());
      else if (p < 76) begin
        // ignored load: row or rhs outside the active range
        if (n < ORDER_MAX && (m == RHS_MAX || $urandom_range(1)))
          load(10'($urandom_range(ORDER_MAX - 1, n)), 2'($urandom), $urandom, $urandom);
        else if (m < RHS_MAX)
          load(10'(rr), 2'($urandom_range(RHS_MAX - 1, m)), $urandom, $urandom);
      end else if (p < 84) begin
        if (n < ORDER_MAX) entry(10'(rr), 10'($urandom_range(ORDER_MAX - 1, n)), $urandom);
      end else if (p < 90)
        send(sspmv_pkg::FUNC_NONE, 10'($urandom), 10'($urandom), $urandom, 2'($urandom),
             $urandom, $urandom);
      else
        evaluate();
    end
    evaluate();
  endtask

  initial begin
    words_sent = 0;
    evals_sent = 0;
    cycles = 0;
    no_gaps = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single row, single rhs: extremes and saturation
    write_reg(sspmv_pkg::CFG_MATRIX_ORDER, 11'd1);
    write_reg(sspmv_pkg::CFG_RHS_COUNT, 3'd1);
    load(0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    load(1, 1, $urandom, $urandom);
    evaluate();
    repeat (3) entry(0, 0, 32'h7FFF_FFFF);
    evaluate();
    repeat (3) entry(0, 0, 32'h8000_0000);
    entry(0, 1, 32'h7FFF_FFFF);
    send(sspmv_pkg::FUNC_NONE, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF,
         32'hFFFF_FFFF);
    evaluate();

    // zero register values act as one
    write_reg(sspmv_pkg::CFG_MATRIX_ORDER, 11'd0);
    write_reg(sspmv_pkg::CFG_RHS_COUNT, 3'd0);
    load(0, 0, 32'h0001_0000, 32'h0000_8000);
    entry(0, 0, 32'h0000_8000);
    evaluate();

    // three rows, two rhs: lower-triangle entry and out-of-range column
    write_reg(sspmv_pkg::CFG_MATRIX_ORDER, 11'd3);
    write_reg(sspmv_pkg::CFG_RHS_COUNT, 3'd2);
    fill_vectors();
    entry(0, 2, 32'h0002_0000);
    entry(2, 0, 32'hFFFF_0000);
    entry(1, 1, 32'h0000_0001);
    entry(1, 3, 32'h0001_0000);
    evaluate();

    // long stretch with no gaps, then an oversized rhs count
    no_gaps = 1'b1;
    random_phase(11'd12, 3'd1, 16);
    no_gaps = 1'b0;
    random_phase(11'd5, 3'd7, 14);

    for (int ph = 0; ph < 5; ph++)
      random_phase(11'($urandom_range(2, 8)), 11'($urandom_range(1, 4)), 14);

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.residual_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.residual_q.size()));
    $display("sent %0d command words with %0d evaluates, checked %0d results",
             words_sent, evals_sent, sb.n_checked);
    $display("orders 1 to 12, zero and oversized register values, 1 to 4 rhs, saturation, ignored words");
    if (sb.errors == 0)
      $display("symmetric_spmv_residual_check: match");
    else
      $display("symmetric_spmv_residual_check: mismatch");
    $finish;
  end

endmodule
